### hdl/agr_pkg.sv
// Shared types, constants and the blend function of the grain repeater.
package agr_pkg;

  localparam int unsigned RingAddrBits = 15;
  localparam int unsigned SampleBits   = 16;
  localparam int unsigned GrainBits    = 15;
  localparam int unsigned MixBits      = 16;
  localparam int unsigned CfgIdxBits   = 2;
  localparam int unsigned CfgDataBits  = 16;

  localparam logic [CfgIdxBits-1:0] CfgGrainLength  = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgMixLevel     = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgStereoEnable = 2'd2;

  localparam logic [GrainBits-1:0] GrainReset   = 15'd480;
  localparam logic [GrainBits-1:0] GrainMin     = 15'd100;
  localparam logic [MixBits-1:0]   MixOne       = 16'd32768;
  localparam logic [MixBits-1:0]   MixThreshold = 16'd1638;

  // Ring write and read commands from the loop controller.
  typedef struct packed {
    logic                    wr_en;
    logic [RingAddrBits-1:0] wr_addr;
    logic                    rd_en;
    logic [RingAddrBits-1:0] rd_addr;
    logic                    clearing;
  } agr_ring_cmd_t;

  // Per-request information handed to the output stage.
  typedef struct packed {
    logic               active;
    logic               fwd;
    logic [MixBits-1:0] mix;
  } agr_step_t;

  // out = floor((dry*32768 + (wet-dry)*mix + 16384) / 32768); always in range.
  function automatic logic signed [SampleBits-1:0] blend(
    input logic signed [SampleBits-1:0] dry,
    input logic signed [SampleBits-1:0] wet,
    input logic        [MixBits-1:0]    mix
  );
    logic signed [SampleBits:0]   diff;
    logic signed [MixBits+1:0]    mix_s;
    logic signed [34:0]           prod;
    logic signed [34:0]           acc;
    diff  = (SampleBits + 1)'(wet) - (SampleBits + 1)'(dry);
    mix_s = $signed({2'b00, mix});
    prod  = 35'(diff) * 35'(mix_s);
    acc   = prod + (35'(dry) <<< 15) + 35'sd16384;
    return acc[SampleBits+14:15];
  endfunction

endpackage

### hdl/audio_stutter_grain_repeater.sv
// Top level of the stutter grain repeater: config registers, ring and pipeline.
//
// Usage: each input request carries one stereo frame (left_in_i, right_in_i,
// signed Q1.15) and is accepted on a rising edge with in_valid_i high and
// in_stall_o low. Every frame is recorded into a 32768-frame ring. While the
// effective mix level exceeds 1638, the block loops a grain taken one grain
// length behind the write pointer and crossfades it with the dry input.
// Each accepted request yields exactly one output request on left_out_o and
// right_out_o, taken when out_valid_o is high and out_stall_i is low.
// The accepting edge registers the ring read, the pointer update and the dry
// frame in the middle stage; the blended frame then moves into the output
// register, raising out_valid_o, as soon as that register is free. Throughput
// is one request per cycle while in_stall_o is low, set by the single ring
// read and write port. After reset all 32768 ring entries are cleared to zero,
// one per cycle; in_stall_o stays high during that pass. Config writes through
// cfg_we_i, cfg_idx_i and cfg_wdata_i are taken at any time, but should only
// be issued while the block is idle.
// When the receiver stalls, the output request holds its value, the middle
// stage takes one more request if it is empty, and then in_stall_o goes high.
module audio_stutter_grain_repeater (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [agr_pkg::CfgIdxBits-1:0]        cfg_idx_i,
  input  logic [agr_pkg::CfgDataBits-1:0]       cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [agr_pkg::SampleBits-1:0] left_in_i,
  input  logic signed [agr_pkg::SampleBits-1:0] right_in_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [agr_pkg::SampleBits-1:0] left_out_o,
  output logic signed [agr_pkg::SampleBits-1:0] right_out_o
);

  logic [agr_pkg::GrainBits-1:0]  grain_len_q;
  logic [agr_pkg::MixBits-1:0]    mix_q;
  logic                           stereo_q;

  logic                           accept;
  logic                           hold;
  agr_pkg::agr_ring_cmd_t         cmd;
  agr_pkg::agr_step_t             step;
  logic [agr_pkg::SampleBits-1:0] left_wdata, right_wdata;
  logic [agr_pkg::SampleBits-1:0] left_rdata, right_rdata;

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grain_len_q <= agr_pkg::GrainReset;
      mix_q       <= '0;
      stereo_q    <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        agr_pkg::CfgGrainLength:  grain_len_q <= cfg_wdata_i[agr_pkg::GrainBits-1:0];
        agr_pkg::CfgMixLevel:     mix_q       <= cfg_wdata_i[agr_pkg::MixBits-1:0];
        agr_pkg::CfgStereoEnable: stereo_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Input is held off during the clearing pass and while the pipeline is full.
  assign in_stall_o = cmd.clearing | hold;
  assign accept     = in_valid_i & ~in_stall_o;

  agr_loop_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .grain_len_i (grain_len_q),
    .mix_i       (mix_q),
    .cmd_o       (cmd),
    .step_o      (step)
  );

  // During the clearing pass the ring is written with zeros.
  assign left_wdata  = cmd.clearing ? '0 : left_in_i;
  assign right_wdata = cmd.clearing ? '0 : right_in_i;

  agr_ring_ram #(
    .ADDR_BITS (agr_pkg::RingAddrBits),
    .DATA_BITS (agr_pkg::SampleBits)
  ) u_ram_left (
    .clk_i   (clk_i),
    .we_i    (cmd.wr_en),
    .waddr_i (cmd.wr_addr),
    .wdata_i (left_wdata),
    .re_i    (cmd.rd_en),
    .raddr_i (cmd.rd_addr),
    .rdata_o (left_rdata)
  );

  // In mono mode the right half of the ring keeps its earlier contents.
  agr_ring_ram #(
    .ADDR_BITS (agr_pkg::RingAddrBits),
    .DATA_BITS (agr_pkg::SampleBits)
  ) u_ram_right (
    .clk_i   (clk_i),
    .we_i    (cmd.clearing | (accept & stereo_q)),
    .waddr_i (cmd.wr_addr),
    .wdata_i (right_wdata),
    .re_i    (cmd.rd_en),
    .raddr_i (cmd.rd_addr),
    .rdata_o (right_rdata)
  );

  agr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .left_dry_i  (left_in_i),
    .right_dry_i (right_in_i),
    .stereo_i    (stereo_q),
    .step_i      (step),
    .left_wet_i  ($signed(left_rdata)),
    .right_wet_i ($signed(right_rdata)),
    .out_stall_i (out_stall_i),
    .hold_o      (hold),
    .out_valid_o (out_valid_o),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o)
  );

endmodule

### hdl/agr_ring_ram.sv
// Simple dual-port RAM with registered read data, used for the sample ring.
module agr_ring_ram #(
  parameter int unsigned ADDR_BITS = 15,
  parameter int unsigned DATA_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [DATA_BITS-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [DATA_BITS-1:0] rdata_o
);

  logic [DATA_BITS-1:0] mem_q [2**ADDR_BITS];
  logic [DATA_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/agr_loop_ctrl.sv
// Write, replay and grain pointers plus the ring clearing pass after reset.
module agr_loop_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic [agr_pkg::GrainBits-1:0]       grain_len_i,
  input  logic [agr_pkg::MixBits-1:0]         mix_i,
  output agr_pkg::agr_ring_cmd_t              cmd_o,
  output agr_pkg::agr_step_t                  step_o
);

  logic [agr_pkg::RingAddrBits-1:0] write_q, replay_q, replay_d, clr_q;
  logic [agr_pkg::GrainBits-1:0]    pos_q, pos;
  logic                             looping_q, clearing_q;
  logic [agr_pkg::GrainBits-1:0]    grain_eff;
  logic [agr_pkg::MixBits-1:0]      mix_eff;
  logic                             active;
  logic [agr_pkg::RingAddrBits-1:0] base, rd_next;
  logic [agr_pkg::GrainBits:0]      pos_inc;
  logic                             wrap;

  always_comb begin
    grain_eff = (grain_len_i < agr_pkg::GrainMin) ? agr_pkg::GrainMin : grain_len_i;
    mix_eff   = (mix_i > agr_pkg::MixOne) ? agr_pkg::MixOne : mix_i;
    active    = mix_eff > agr_pkg::MixThreshold;
    base      = looping_q ? replay_q : (write_q - agr_pkg::RingAddrBits'(grain_eff));
    pos       = looping_q ? pos_q : '0;
    pos_inc   = {1'b0, pos} + 1'b1;
    wrap      = pos_inc >= {1'b0, grain_eff};
    rd_next   = base + 1'b1;
    replay_d  = wrap ? (rd_next - agr_pkg::RingAddrBits'(grain_eff)) : rd_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_q    <= '0;
      replay_q   <= '0;
      pos_q      <= '0;
      looping_q  <= 1'b0;
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else begin
      if (clearing_q) begin
        clr_q <= clr_q + 1'b1;
        if (&clr_q) begin
          clearing_q <= 1'b0;
        end
      end
      if (accept_i) begin
        write_q <= write_q + 1'b1;
        if (active) begin
          replay_q  <= replay_d;
          pos_q     <= wrap ? '0 : pos_inc[agr_pkg::GrainBits-1:0];
          looping_q <= 1'b1;
        end else begin
          looping_q <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    cmd_o.wr_en    = clearing_q | accept_i;
    cmd_o.wr_addr  = clearing_q ? clr_q : write_q;
    cmd_o.rd_en    = accept_i;
    cmd_o.rd_addr  = base;
    cmd_o.clearing = clearing_q;
    step_o.active  = active;
    step_o.fwd     = base == write_q;
    step_o.mix     = mix_eff;
  end

endmodule

### hdl/agr_out_stage.sv
// Blend stage and output register with stall handling.
module agr_out_stage (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  load_i,
  input  logic signed [agr_pkg::SampleBits-1:0] left_dry_i,
  input  logic signed [agr_pkg::SampleBits-1:0] right_dry_i,
  input  logic                                  stereo_i,
  input  agr_pkg::agr_step_t                    step_i,
  input  logic signed [agr_pkg::SampleBits-1:0] left_wet_i,
  input  logic signed [agr_pkg::SampleBits-1:0] right_wet_i,
  input  logic                                  out_stall_i,
  output logic                                  hold_o,
  output logic                                  out_valid_o,
  output logic signed [agr_pkg::SampleBits-1:0] left_out_o,
  output logic signed [agr_pkg::SampleBits-1:0] right_out_o
);

  logic                                  s1_valid_q, out_valid_q, out_free;
  logic                                  s1_stereo_q;
  agr_pkg::agr_step_t                    s1_step_q;
  logic signed [agr_pkg::SampleBits-1:0] s1_left_q, s1_right_q;
  logic signed [agr_pkg::SampleBits-1:0] left_q, right_q, left_d, right_d;
  logic signed [agr_pkg::SampleBits-1:0] left_wet, right_wet;

  assign out_free = !out_valid_q || !out_stall_i;
  assign hold_o   = s1_valid_q && !out_free;

  always_comb begin
    // A replay of the entry written by this same request sees the fresh sample.
    left_wet  = s1_step_q.fwd ? s1_left_q : left_wet_i;
    right_wet = s1_step_q.fwd ? s1_right_q : right_wet_i;
    left_d    = s1_left_q;
    right_d   = s1_right_q;
    if (s1_step_q.active) begin
      left_d = agr_pkg::blend(s1_left_q, left_wet, s1_step_q.mix);
      if (s1_stereo_q) begin
        right_d = agr_pkg::blend(s1_right_q, right_wet, s1_step_q.mix);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        s1_valid_q <= 1'b1;
      end else if (out_free) begin
        s1_valid_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_left_q   <= left_dry_i;
      s1_right_q  <= right_dry_i;
      s1_stereo_q <= stereo_i;
      s1_step_q   <= step_i;
    end
    if (out_free && s1_valid_q) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_q;
  assign right_out_o = right_q;

endmodule

### hdl/agr_checker.sv
// Port-level checker for the grain repeater, bound to the top level.
module agr_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  cfg_we_i,
  input logic [agr_pkg::CfgIdxBits-1:0]        cfg_idx_i,
  input logic [agr_pkg::CfgDataBits-1:0]       cfg_wdata_i,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic signed [agr_pkg::SampleBits-1:0] left_in_i,
  input logic signed [agr_pkg::SampleBits-1:0] right_in_i,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic signed [agr_pkg::SampleBits-1:0] left_out_o,
  input logic signed [agr_pkg::SampleBits-1:0] right_out_o
);

  // A stalled output request stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output request dropped while stalled");

  // A stalled output request keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(left_out_o) && $stable(right_out_o))
    else $error("output payload changed while stalled");

  // Right after reset the ring clearing pass holds off the input.
  assert property (@(posedge clk_i)
    rst_ni && !$past(rst_ni) |-> in_stall_o)
    else $error("input not stalled at start of clearing pass");

  // A fresh output request follows an accepted input request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("output request without matching input request");

endmodule

bind audio_stutter_grain_repeater agr_checker u_agr_checker (.*);

### sim/tb.sv
// Self-checking testbench for the stutter grain repeater: directed and random cases.
`timescale 1ns / 1ps

// Testbench for audio_stutter_grain_repeater.
//
// The run has two parts. A short directed part goes through the edges of the
// register and sample ranges:
// - full-scale samples
// - a grain below the minimum
// - mix above full scale, at the threshold and just over it
// - a 16-bit write into the 15-bit grain register
// - mono with spare upper data bits
// The random part then runs a series of setting phases with random frames.
// Its register writes are chosen so that loops often survive across a change
// of grain or mix.
//
// Each accepted input request goes through a behavioral copy of the effect:
// its own ring, write and replay pointers, grain counter and loop flag, and a
// shadow of the three registers. That copy produces one expected frame per
// request. The output monitor compares each accepted output request, field
// by field, with the oldest expected frame. Register writes happen only
// while the block is drained, so the shadow copy always matches the settings
// that the block used.
module tb;

  localparam int unsigned RingDepth = 1 << agr_pkg::RingAddrBits;
  localparam int unsigned FrameTarget = 1650;

  typedef logic signed [agr_pkg::SampleBits-1:0] sample_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } frame_t;

  typedef enum logic [1:0] {
    StallNone,
    StallLight,
    StallHeavy,
    StallPeriodic
  } stall_mode_e;

  // DUT inputs start at known values. Reset is held from time zero.
  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [agr_pkg::CfgIdxBits-1:0]  cfg_idx_i = agr_pkg::CfgGrainLength;
  logic [agr_pkg::CfgDataBits-1:0] cfg_wdata_i = '0;
  logic                            in_valid_i = 1'b0;
  sample_t                         left_in_i = '0;
  sample_t                         right_in_i = '0;
  logic                            out_stall_i = 1'b0;
  logic                            in_stall_o;
  logic                            out_valid_o;
  sample_t                         left_out_o;
  sample_t                         right_out_o;

  audio_stutter_grain_repeater dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .left_in_i   (left_in_i),
    .right_in_i  (right_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow copy of the register file, updated when a write is issued.
  logic [agr_pkg::GrainBits-1:0] grain_cfg;
  logic [agr_pkg::MixBits-1:0]   mix_cfg;
  logic                          stereo_cfg;

  // State of the behavioral effect: the recorded history and the loop pointers.
  sample_t     hist_l [RingDepth];
  sample_t     hist_r [RingDepth];
  int unsigned wr_ptr;
  int unsigned rd_ptr;
  int unsigned grain_pos;
  bit          loop_on;

  frame_t pending_q [$];  // Frames waiting to be offered to the block.
  frame_t expected_q [$];  // Output frames the block still owes.

  int unsigned frames_queued;
  int unsigned frames_accepted;
  int unsigned frames_looped;
  int unsigned frames_mono;
  int unsigned frames_checked;
  int unsigned phases_run;
  int unsigned errors;

  // Sender pacing.
  int unsigned burst_left;
  int unsigned gap_left;
  frame_t      next_frame;

  // Receiver pacing.
  stall_mode_e stall_mode;
  logic [31:0] cycle_cnt;
  frame_t      want;

  // Rounded crossfade: floor((dry*(1-m) + wet*m + half) / one), all in Q1.15.
  // The two weights sum to one, so the result never leaves the sample range.
  function automatic sample_t crossfade(input sample_t dry, input sample_t wet,
                                        input int unsigned m);
    longint acc;
    acc = longint'(dry) * (longint'(agr_pkg::MixOne) - longint'(m))
          + longint'(wet) * longint'(m) + 64'sd16384;
    return sample_t'(acc >>> 15);
  endfunction

  function automatic int unsigned ring_back(input int unsigned idx, input int unsigned amt);
    return (idx + RingDepth - amt) % RingDepth;
  endfunction

  // Advances the behavioral effect by one input frame and records the frame
  // the block has to produce for it.
  task automatic stutter_predict(input sample_t l_in, input sample_t r_in);
    int unsigned g;
    int unsigned m;
    frame_t      res;
    g = grain_cfg;
    if (g < agr_pkg::GrainMin) g = agr_pkg::GrainMin;
    if (g > RingDepth) g = RingDepth;
    m = mix_cfg;
    if (m > agr_pkg::MixOne) m = agr_pkg::MixOne;
    res.left = l_in;
    res.right = r_in;
    // The frame is recorded before the replay read, as the block does.
    hist_l[wr_ptr] = l_in;
    if (stereo_cfg) hist_r[wr_ptr] = r_in;
    else frames_mono++;
    if (m > agr_pkg::MixThreshold) begin
      // The first wet frame freezes the replay pointer one grain back.
      if (!loop_on) begin
        rd_ptr = ring_back(wr_ptr, g);
        loop_on = 1'b1;
        grain_pos = 0;
      end
      res.left = crossfade(l_in, hist_l[rd_ptr], m);
      if (stereo_cfg) res.right = crossfade(r_in, hist_r[rd_ptr], m);
      rd_ptr = (rd_ptr + 1) % RingDepth;
      grain_pos++;
      // The wrap uses the grain length now in force, so a changed length acts
      // at the next compare.
      if (grain_pos >= g) begin
        rd_ptr = ring_back(rd_ptr, g);
        grain_pos = 0;
      end
      frames_looped++;
    end else begin
      loop_on = 1'b0;
    end
    wr_ptr = (wr_ptr + 1) % RingDepth;
    expected_q.push_back(res);
  endtask

  // Mostly uniform samples, with the full-scale and near-zero codes mixed in.
  function automatic sample_t rand_sample();
    int unsigned pick;
    pick = $urandom_range(0, 11);
    if (pick == 0) return sample_t'(16'h7FFF);
    if (pick == 1) return sample_t'(16'h8000);
    if (pick == 2) return sample_t'(16'h0000);
    if (pick == 3) return sample_t'(16'hFFFF);
    return sample_t'($urandom);
  endfunction

  task automatic queue_frame(input sample_t l, input sample_t r);
    frame_t f;
    f.left = l;
    f.right = r;
    pending_q.push_back(f);
    frames_queued++;
  endtask

  // Blocks the caller until every queued frame has been taken and every
  // expected output has arrived. The check runs on the falling edge, when all
  // clocked updates have settled.
  task automatic drain_to_idle();
    @(negedge clk_i);
    while (pending_q.size() != 0 || in_valid_i || expected_q.size() != 0) @(negedge clk_i);
    repeat (3) @(posedge clk_i);
    phases_run++;
  endtask

  task automatic cfg_write(input logic [agr_pkg::CfgIdxBits-1:0] idx,
                           input logic [agr_pkg::CfgDataBits-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      agr_pkg::CfgGrainLength:  grain_cfg = data[agr_pkg::GrainBits-1:0];
      agr_pkg::CfgMixLevel:     mix_cfg = data;
      agr_pkg::CfgStereoEnable: stereo_cfg = data[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Sender. A request is retired when valid is high and stall is low. The next
  // one is presented right after, unless a gap between bursts is running or no
  // frame is pending. A stalled request is held as it is.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        stutter_predict(left_in_i, right_in_i);
        frames_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0 || pending_q.size() == 0) begin
          in_valid_i <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          next_frame = pending_q.pop_front();
          in_valid_i <= 1'b1;
          left_in_i <= next_frame.left;
          right_in_i <= next_frame.right;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 60);
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30)
                                                    : $urandom_range(0, 4);
          end
        end
      end
    end
  end

  // Receiver. It checks each retired output request against the oldest
  // expectation. Its stall line follows a randomly redrawn mode: no stall,
  // light or heavy random stalls, or a fixed periodic pattern.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 100)
            $display("%0t ns: output with nothing expected, expected none, actual %0d / %0d",
                     $time, left_out_o, right_out_o);
        end else begin
          want = expected_q.pop_front();
          frames_checked++;
          if (left_out_o !== want.left) begin
            errors++;
            if (errors <= 100)
              $display("%0t ns: left_out mismatch, expected %0d, actual %0d",
                       $time, $signed(want.left), left_out_o);
          end
          if (right_out_o !== want.right) begin
            errors++;
            if (errors <= 100)
              $display("%0t ns: right_out mismatch, expected %0d, actual %0d",
                       $time, $signed(want.right), right_out_o);
          end
        end
      end
      cycle_cnt++;
      if (cycle_cnt % 300 == 0) stall_mode = stall_mode_e'($urandom_range(0, 3));
      case (stall_mode)
        StallNone:  out_stall_i <= 1'b0;
        StallLight: out_stall_i <= ($urandom_range(0, 3) == 0);
        StallHeavy: out_stall_i <= ($urandom_range(0, 1) == 0);
        default:    out_stall_i <= (cycle_cnt[3:2] == 2'b11);
      endcase
    end
  end

  // Time limit. Normal runs, including the ring clear after reset, finish in
  // well under a tenth of this.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int unsigned pick;
    int unsigned count;
    logic [agr_pkg::CfgDataBits-1:0] wdata;
    foreach (hist_l[i]) begin
      hist_l[i] = '0;
      hist_r[i] = '0;
    end
    wr_ptr = 0;
    rd_ptr = 0;
    grain_pos = 0;
    loop_on = 1'b0;
    grain_cfg = agr_pkg::GrainReset;
    mix_cfg = '0;
    stereo_cfg = 1'b1;
    frames_queued = 0;
    frames_accepted = 0;
    frames_looped = 0;
    frames_mono = 0;
    frames_checked = 0;
    phases_run = 0;
    errors = 0;
    burst_left = 1;
    gap_left = 0;
    stall_mode = StallNone;
    cycle_cnt = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Reset settings give a dry path, checked at full scale.
    queue_frame(sample_t'(16'h7FFF), sample_t'(16'h8000));
    queue_frame(sample_t'(16'h8000), sample_t'(16'h7FFF));
    queue_frame(sample_t'(16'h0000), sample_t'(16'hFFFF));
    queue_frame(sample_t'(16'hFFFF), sample_t'(16'h0000));
    drain_to_idle();

    // A grain of zero acts as the minimum grain. Mix beyond full scale acts as
    // fully wet, so these frames replay the cleared history.
    cfg_write(agr_pkg::CfgGrainLength, 16'd0);
    cfg_write(agr_pkg::CfgMixLevel, 16'hFFFF);
    queue_frame(sample_t'(16'h7FFF), sample_t'(16'h7FFF));
    queue_frame(sample_t'(16'h8000), sample_t'(16'h8000));
    queue_frame(sample_t'(16'h1234), sample_t'(16'hEDCB));
    queue_frame(sample_t'(16'hFFFF), sample_t'(16'h0001));
    drain_to_idle();

    // Mix exactly at the threshold releases the loop.
    cfg_write(agr_pkg::CfgMixLevel, agr_pkg::MixThreshold);
    queue_frame(sample_t'(16'h4000), sample_t'(16'hC000));
    queue_frame(sample_t'(16'h7FFF), sample_t'(16'h8000));
    drain_to_idle();

    // The write sets all 16 data bits; the grain register keeps the low 15. Mix is
    // one step over the threshold, which starts a fresh loop.
    cfg_write(agr_pkg::CfgGrainLength, 16'hFFFF);
    cfg_write(agr_pkg::CfgMixLevel, agr_pkg::MixThreshold + 16'd1);
    queue_frame(sample_t'(16'h8000), sample_t'(16'h7FFF));
    queue_frame(sample_t'(16'h7FFF), sample_t'(16'h8000));
    queue_frame(sample_t'(16'h0101), sample_t'(16'hFEFE));
    drain_to_idle();

    // Mono with the spare data bits set: the right channel must pass straight.
    cfg_write(agr_pkg::CfgStereoEnable, 16'hFFFE);
    cfg_write(agr_pkg::CfgMixLevel, agr_pkg::MixOne);
    cfg_write(agr_pkg::CfgGrainLength, 16'(agr_pkg::GrainMin));
    queue_frame(sample_t'(16'h7FFF), sample_t'(16'h8000));
    queue_frame(sample_t'(16'h8000), sample_t'(16'h7FFF));
    queue_frame(sample_t'(16'h5555), sample_t'(16'hAAAA));
    queue_frame(sample_t'(16'hAAAA), sample_t'(16'h5555));
    drain_to_idle();

    // Stereo again, at the longest grain of the usual range and half mix.
    cfg_write(agr_pkg::CfgStereoEnable, 16'h0001);
    cfg_write(agr_pkg::CfgMixLevel, 16'd16384);
    cfg_write(agr_pkg::CfgGrainLength, 16'd16384);
    queue_frame(sample_t'(16'h7FFF), sample_t'(16'h7FFF));
    queue_frame(sample_t'(16'h8000), sample_t'(16'h8000));
    queue_frame(sample_t'(16'h0F0F), sample_t'(16'hF0F0));
    drain_to_idle();

    // Random part. Each phase may rewrite any register. The mix is often left
    // alone, so a running loop carries on across a change of grain length.
    // Short grains dominate, so loops often wrap within a phase.
    while (frames_queued < FrameTarget) begin
      if ($urandom_range(0, 2) != 0) begin
        pick = $urandom_range(0, 9);
        if (pick <= 5) wdata = agr_pkg::CfgDataBits'($urandom_range(100, 300));
        else if (pick == 6) wdata = agr_pkg::CfgDataBits'($urandom_range(0, 99));
        else if (pick == 7) wdata = agr_pkg::CfgDataBits'($urandom_range(301, 2000));
        else if (pick == 8) wdata = agr_pkg::CfgDataBits'($urandom_range(2001, 16384));
        else wdata = agr_pkg::CfgDataBits'($urandom);
        cfg_write(agr_pkg::CfgGrainLength, wdata);
      end
      if ($urandom_range(0, 1) == 0) begin
        pick = $urandom_range(0, 9);
        if (pick <= 1) wdata = agr_pkg::CfgDataBits'($urandom_range(0, 1638));
        else if (pick == 2)
          wdata = agr_pkg::MixThreshold + agr_pkg::CfgDataBits'($urandom_range(0, 1));
        else if (pick <= 4) wdata = agr_pkg::CfgDataBits'($urandom_range(32768, 65535));
        else wdata = agr_pkg::CfgDataBits'($urandom_range(1639, 32767));
        cfg_write(agr_pkg::CfgMixLevel, wdata);
      end
      if ($urandom_range(0, 4) == 0) begin
        wdata = agr_pkg::CfgDataBits'($urandom);
        wdata[0] = ($urandom_range(0, 3) != 0);
        cfg_write(agr_pkg::CfgStereoEnable, wdata);
      end
      count = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 10) : $urandom_range(30, 250);
      repeat (count) queue_frame(rand_sample(), rand_sample());
      drain_to_idle();
    end

    repeat (10) @(posedge clk_i);
    $display("Covered %0d frames in %0d setting phases: %0d replayed from a looped grain, %0d mono.",
             frames_accepted, phases_run, frames_looped, frames_mono);
    $display("Compared %0d output frames, %0d field errors.", frames_checked, errors);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
